>>> hdl/dbr_pkg.sv
// Shared types and constants for the compressed block reorientation unit.
package dbr_pkg;

    // Largest level edge in texels; level sizes saturate to [1, MAX_LEVEL_DIM].
    localparam int MAX_LEVEL_DIM = 4096;

    // Widths of the level dimension, block count and block coordinate.
    localparam int DIM_W   = 13;
    localparam int BLKS_W  = 11;
    localparam int COORD_W = 10;
    localparam int DEST_W  = 20;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_FORMAT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_X        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_Y        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSPOSE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_MAP_MODE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_WIDTH     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_HEIGHT    = 3'd6;

    // Block format codes.
    localparam logic [1:0] FMT_DXT1_RGB  = 2'd0;
    localparam logic [1:0] FMT_DXT1_RGBA = 2'd1;
    localparam logic [1:0] FMT_DXT3      = 2'd2;
    localparam logic [1:0] FMT_DXT5      = 2'd3;

    // Reciprocal of 63 scaled by 2^20, rounded up, for the green-to-red rescale.
    localparam logic [14:0] RECIP_63    = 15'd16645;
    localparam int          RECIP_SHIFT = 20;

    typedef struct packed {
        logic [63:0]        block_low;
        logic [63:0]        block_high;
        logic [COORD_W-1:0] block_col;
        logic [COORD_W-1:0] block_row;
    } blk_item_t;

    typedef struct packed {
        logic [63:0]       out_low;
        logic [63:0]       out_high;
        logic [DEST_W-1:0] dest_index;
    } res_item_t;

endpackage

>>> hdl/dxt_block_reorient.sv
// Top level of the S3TC block reorientation unit: one registered pass per block.
//
// This unit takes one compressed 4x4 DXT1, DXT3 or DXT5 block per item together
// with its block column and row, and returns the block mirrored in X and/or Y
// and/or transposed, with its row-major index in the destination level. It
// accepts one item in every clock cycle unless the input and result registers
// both hold items and the result is not being taken. An input register holds
// the item, all per-texel index moves, endpoint adjustment and the destination
// index product are done in the logic behind it, and a result register holds
// the outcome. The result register lets a new item enter while an earlier
// result still waits to be taken. Configuration registers are written through
// a simple write port and must only change while no item is in flight; values
// derived from them (block counts, covered texel counts and the texel slot
// map) settle in the cycle after a write.
module dxt_block_reorient
    import dbr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   blk_valid,
    output logic                   blk_ready,
    input  blk_item_t              blk_item,

    output logic                   res_valid,
    input  logic                   res_ready,
    output res_item_t              res_item
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [1:0]       block_format_reg;
    logic             mirror_x_reg;
    logic             mirror_y_reg;
    logic             transpose_reg;
    logic             normal_map_mode_reg;
    logic [DIM_W-1:0] level_width_reg;
    logic [DIM_W-1:0] level_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_format_reg    <= FMT_DXT1_RGB;
            mirror_x_reg        <= 1'b0;
            mirror_y_reg        <= 1'b0;
            transpose_reg       <= 1'b0;
            normal_map_mode_reg <= 1'b0;
            level_width_reg     <= DIM_W'(4);
            level_height_reg    <= DIM_W'(4);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLOCK_FORMAT:    block_format_reg    <= cfg_data[1:0];
                REG_MIRROR_X:        mirror_x_reg        <= cfg_data[0];
                REG_MIRROR_Y:        mirror_y_reg        <= cfg_data[0];
                REG_TRANSPOSE:       transpose_reg       <= cfg_data[0];
                REG_NORMAL_MAP_MODE: normal_map_mode_reg <= cfg_data[0];
                REG_LEVEL_WIDTH:     level_width_reg     <= cfg_data[DIM_W-1:0];
                REG_LEVEL_HEIGHT:    level_height_reg    <= cfg_data[DIM_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Values derived from the configuration. They are registered so that
    // the per-item path starts from settled block counts and slot maps.
    // ------------------------------------------------------------------
    logic [BLKS_W-1:0]  blks_w_reg, blks_w_next;
    logic [BLKS_W-1:0]  blks_h_reg, blks_h_next;
    logic [COORD_W-1:0] last_col_reg, last_col_next;
    logic [COORD_W-1:0] last_row_reg, last_row_next;
    logic [15:0][3:0]   slot_src_reg, slot_src_next;
    logic [15:0]        slot_ok_reg, slot_ok_next;

    always_comb
    begin
        logic [DIM_W-1:0] w_sat;
        logic [DIM_W-1:0] h_sat;
        logic [DIM_W-1:0] w_up;
        logic [DIM_W-1:0] h_up;
        logic [2:0]       wc;
        logic [2:0]       hc;
        logic [1:0]       hi_part;
        logic [1:0]       lo_part;
        logic [1:0]       dx;
        logic [1:0]       dy;
        logic [1:0]       sx;
        logic [1:0]       sy;

        // Saturate the level size to the supported range.
        if (level_width_reg == '0)
            w_sat = DIM_W'(1);
        else if (level_width_reg > DIM_W'(MAX_LEVEL_DIM))
            w_sat = DIM_W'(MAX_LEVEL_DIM);
        else
            w_sat = level_width_reg;

        if (level_height_reg == '0)
            h_sat = DIM_W'(1);
        else if (level_height_reg > DIM_W'(MAX_LEVEL_DIM))
            h_sat = DIM_W'(MAX_LEVEL_DIM);
        else
            h_sat = level_height_reg;

        w_up        = w_sat + DIM_W'(3);
        h_up        = h_sat + DIM_W'(3);
        blks_w_next = w_up[DIM_W-1:2];
        blks_h_next = h_up[DIM_W-1:2];
        last_col_next = COORD_W'(blks_w_next - BLKS_W'(1));
        last_row_next = COORD_W'(blks_h_next - BLKS_W'(1));

        // Texels covered inside one block for levels narrower than a block.
        wc = (w_sat < DIM_W'(4)) ? w_sat[2:0] : 3'd4;
        hc = (h_sat < DIM_W'(4)) ? h_sat[2:0] : 3'd4;

        // For every destination slot, find the source slot that lands there.
        // Mirroring is undone in source axes after the transpose is undone.
        for (int p = 0; p < 16; p++)
        begin
            hi_part = 2'(p >> 2);
            lo_part = 2'(p);
            dx = transpose_reg ? hi_part : lo_part;
            dy = transpose_reg ? lo_part : hi_part;
            sx = mirror_x_reg ? 2'(wc - 3'd1 - {1'b0, dx}) : dx;
            sy = mirror_y_reg ? 2'(hc - 3'd1 - {1'b0, dy}) : dy;
            slot_ok_next[p]  = ({1'b0, dx} < wc) && ({1'b0, dy} < hc);
            slot_src_next[p] = {sy, sx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blks_w_reg   <= BLKS_W'(1);
            blks_h_reg   <= BLKS_W'(1);
            last_col_reg <= '0;
            last_row_reg <= '0;
            slot_src_reg <= '0;
            slot_ok_reg  <= '0;
        end
        else
        begin
            blks_w_reg   <= blks_w_next;
            blks_h_reg   <= blks_h_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            slot_src_reg <= slot_src_next;
            slot_ok_reg  <= slot_ok_next;
        end
    end

    // ------------------------------------------------------------------
    // Index moves. Each destination slot selects its source slot, or zero
    // when no covered texel reaches it.
    // ------------------------------------------------------------------
    function automatic logic [31:0] move_2bit(input logic [31:0] idx,
                                              input logic [15:0][3:0] src,
                                              input logic [15:0] ok);
        logic [31:0] res;
        res = '0;
        for (int p = 0; p < 16; p++)
        begin
            res[p*2 +: 2] = ok[p] ? idx[{src[p], 1'b0} +: 2] : 2'b00;
        end
        return res;
    endfunction

    function automatic logic [47:0] move_3bit(input logic [47:0] idx,
                                              input logic [15:0][3:0] src,
                                              input logic [15:0] ok);
        logic [47:0] res;
        res = '0;
        for (int p = 0; p < 16; p++)
        begin
            res[p*3 +: 3] = ok[p] ? idx[6'(src[p]) * 6'd3 +: 3] : 3'b000;
        end
        return res;
    endfunction

    function automatic logic [63:0] move_4bit(input logic [63:0] idx,
                                              input logic [15:0][3:0] src,
                                              input logic [15:0] ok);
        logic [63:0] res;
        res = '0;
        for (int p = 0; p < 16; p++)
        begin
            res[p*4 +: 4] = ok[p] ? idx[{src[p], 2'b00} +: 4] : 4'b0000;
        end
        return res;
    endfunction

    // Normal-map endpoint adjustment of one RGB565 value. Negating a field
    // against its full scale is its bitwise complement. The transpose swaps
    // red and green, rescaling with truncation: 5 to 6 bits is r*2 plus one
    // at full scale, 6 to 5 bits is g*31/63 by a scaled reciprocal.
    function automatic logic [15:0] adjust_normal(input logic [15:0] c,
                                                  input logic mx,
                                                  input logic my,
                                                  input logic tr);
        logic [4:0]  r;
        logic [5:0]  g;
        logic [10:0] g31;
        logic [25:0] scaled;
        logic [4:0]  r_new;
        logic [5:0]  g_new;
        r = mx ? ~c[15:11] : c[15:11];
        g = my ? ~c[10:5] : c[10:5];
        g31    = 11'(g) * 11'd31;
        scaled = 26'(g31) * 26'(RECIP_63);
        r_new  = scaled[RECIP_SHIFT +: 5];
        g_new  = {r, 1'b0} | {5'b00000, (r == 5'd31)};
        if (tr)
            return {r_new, g_new, c[4:0]};
        else
            return {r, g, c[4:0]};
    endfunction

    function automatic logic [63:0] colour_part(input logic [63:0] c,
                                                input logic nm,
                                                input logic mx,
                                                input logic my,
                                                input logic tr,
                                                input logic [15:0][3:0] src,
                                                input logic [15:0] ok);
        logic [15:0] e0;
        logic [15:0] e1;
        logic [15:0] n0;
        logic [15:0] n1;
        e0 = c[15:0];
        e1 = c[31:16];
        n0 = adjust_normal(e0, mx, my, tr);
        n1 = adjust_normal(e1, mx, my, tr);
        if (nm)
        begin
            // Keep three-colour blocks in three-colour mode.
            if ((e0 <= e1) && (n0 > n1))
            begin
                e0 = n1;
                e1 = n0;
            end
            else
            begin
                e0 = n0;
                e1 = n1;
            end
        end
        return {move_2bit(c[63:32], src, ok), e1, e0};
    endfunction

    // ------------------------------------------------------------------
    // Pipeline: input register, then the reorientation logic, then the
    // result register. The input register advances whenever it is empty, or
    // the result register is empty or its item is being taken.
    // ------------------------------------------------------------------
    logic      in_valid_reg;
    blk_item_t in_item_reg;
    logic      out_valid_reg;
    res_item_t out_item_reg;
    res_item_t out_item_next;
    logic      out_load;

    assign out_load  = in_valid_reg && (!out_valid_reg || res_ready);
    assign blk_ready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (blk_ready)
            begin
                in_valid_reg <= blk_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_ready && blk_valid)
        begin
            in_item_reg <= blk_item;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Reorientation of the item held in the input register.
    always_comb
    begin
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  dc;
        logic [COORD_W-1:0]  dr;
        logic [COORD_W-1:0]  mul_a;
        logic [BLKS_W-1:0]   mul_b;
        logic [COORD_W-1:0]  addend;
        logic [DEST_W-1:0]   dest_full;

        // Block position, saturated to the level and then mirrored.
        col = (in_item_reg.block_col > last_col_reg) ? last_col_reg : in_item_reg.block_col;
        row = (in_item_reg.block_row > last_row_reg) ? last_row_reg : in_item_reg.block_row;
        dc  = mirror_x_reg ? (last_col_reg - col) : col;
        dr  = mirror_y_reg ? (last_row_reg - row) : row;

        // The destination is blks_h wide when transposed, else blks_w wide.
        // The largest index, 1023 * 1024 + 1023, fits the 20-bit field.
        mul_a  = transpose_reg ? dc : dr;
        mul_b  = transpose_reg ? blks_h_reg : blks_w_reg;
        addend = transpose_reg ? dr : dc;
        dest_full = DEST_W'(mul_a) * DEST_W'(mul_b) + DEST_W'(addend);

        out_item_next.dest_index = dest_full;

        case (block_format_reg)
            FMT_DXT3:
            begin
                out_item_next.out_low  = move_4bit(in_item_reg.block_low,
                                                   slot_src_reg, slot_ok_reg);
                out_item_next.out_high = colour_part(in_item_reg.block_high,
                                                     normal_map_mode_reg, mirror_x_reg,
                                                     mirror_y_reg, transpose_reg,
                                                     slot_src_reg, slot_ok_reg);
            end
            FMT_DXT5:
            begin
                // Alpha endpoints stay put; only the 3-bit indices move.
                out_item_next.out_low  = {move_3bit(in_item_reg.block_low[63:16],
                                                    slot_src_reg, slot_ok_reg),
                                          in_item_reg.block_low[15:0]};
                out_item_next.out_high = colour_part(in_item_reg.block_high,
                                                     normal_map_mode_reg, mirror_x_reg,
                                                     mirror_y_reg, transpose_reg,
                                                     slot_src_reg, slot_ok_reg);
            end
            default:
            begin
                // Both DXT1 variants: eight-byte blocks, upper half zero.
                out_item_next.out_low  = colour_part(in_item_reg.block_low,
                                                     normal_map_mode_reg, mirror_x_reg,
                                                     mirror_y_reg, transpose_reg,
                                                     slot_src_reg, slot_ok_reg);
                out_item_next.out_high = '0;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

endmodule
